// File: hdl/pseudocolor_map_replicate_macros.svh
// Assertion macros shared by the checker of the pseudocolor mapper.
`ifndef PSEUDOCOLOR_MAP_REPLICATE_MACROS_SVH
`define PSEUDOCOLOR_MAP_REPLICATE_MACROS_SVH

// same-cycle implication, masked while in reset
`define PCM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, masked while in reset
`define PCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

// same-cycle implication that is also checked during reset
`define PCM_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
	lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// File: hdl/pcm_pkg.sv
// Types, constants and codes shared by the pseudocolor mapper modules.
package pcm_pkg;

	localparam int PCM_TABLE_ENTRIES = 256;
	localparam int MAX_COLUMNS       = 4096;
	localparam int MAX_ROWS          = 4096;
	localparam int MAX_SCALE         = 8;
	localparam int QDEPTH            = 8;

	localparam int POS_W   = 12;
	localparam int SIZE_W  = 13;
	localparam int SCALE_W = 4;
	localparam int SUB_W   = 3;
	localparam int COORD_W = 15;
	localparam int RGB_W   = 24;

	localparam logic [7:0] GRAY_LEVEL = 8'd30;

	typedef enum logic {
		OP_MAP   = 1'b0,
		OP_TABLE = 1'b1
	} op_t;

	// configuration register indexes
	localparam logic [7:0] CFG_MIN_VALUE  = 8'd0;
	localparam logic [7:0] CFG_RECIP      = 8'd1;
	localparam logic [7:0] CFG_FILL_MARK  = 8'd2;
	localparam logic [7:0] CFG_FILL_TOL   = 8'd3;
	localparam logic [7:0] CFG_MAG_LIMIT  = 8'd4;
	localparam logic [7:0] CFG_SCALE      = 8'd5;
	localparam logic [7:0] CFG_COLUMNS    = 8'd6;
	localparam logic [7:0] CFG_ROWS       = 8'd7;

	// effective configuration (sizes and scale already clamped)
	typedef struct packed {
		logic [31:0]        min_value;
		logic [31:0]        recip;
		logic [31:0]        fill_mark;
		logic [31:0]        fill_tol;
		logic [30:0]        mag_limit;
		logic [SCALE_W-1:0] scale;
		logic [SIZE_W-1:0]  ncols;
		logic [SIZE_W-1:0]  nrows;
	} cfg_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] sample;
		logic        nan;
		logic [7:0]  tindex;
		logic [23:0] tcolor;
	} in_item_t;

	// one classified sample waiting for replication
	typedef struct packed {
		logic             missing;
		logic [RGB_W-1:0] rgb;
	} q_item_t;

	typedef struct packed {
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               missing;
		logic               last;
	} pixel_t;

endpackage

// File: hdl/pcm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pcm_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hdl/pcm_front.sv
// Front end: accepts beats, flags missing samples, normalizes, and reads or writes the color table.
module pcm_front import pcm_pkg::*; #(
	parameter int TABLE_ENTRIES = PCM_TABLE_ENTRIES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     in_valid,
	output logic     in_ready,
	input  in_item_t in_item,
	input  logic     pop,
	output logic     push,
	output q_item_t  push_item
);

	localparam int AW    = $clog2(TABLE_ENTRIES);
	localparam int RES_W = $clog2(QDEPTH + 1);
	localparam logic [47:0] TOP = 48'(TABLE_ENTRIES - 1);

	// slots held by map items in flight or queued
	logic [RES_W-1:0] res_q;
	logic             acc;
	logic             acc_map;

	assign in_ready = (res_q < RES_W'(QDEPTH));
	assign acc      = in_valid && in_ready;
	assign acc_map  = acc && (in_item.op == OP_MAP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			case ({acc_map, pop})
				2'b10:   res_q <= res_q + RES_W'(1);
				2'b01:   res_q <= res_q - RES_W'(1);
				default: res_q <= res_q;
			endcase
		end
	end

	// stage 1: register the beat
	logic        vld_s1;
	in_item_t    item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= in_item;
	end

	// stage 1 -> 2: magnitude and differences
	logic [31:0] abs_smp;
	logic [32:0] fdiff;
	logic [32:0] mdiff;

	assign abs_smp = item_s1.sample[31] ? (~item_s1.sample + 32'd1) : item_s1.sample;
	assign fdiff   = {item_s1.sample[31], item_s1.sample}
	               - {cfg.fill_mark[31], cfg.fill_mark};
	assign mdiff   = {item_s1.sample[31], item_s1.sample}
	               - {cfg.min_value[31], cfg.min_value};

	logic        vld_s2;
	op_t         op_s2;
	logic        nan_s2;
	logic [7:0]  tindex_s2;
	logic [23:0] tcolor_s2;
	logic [31:0] abs_smp_s2;
	logic [32:0] fdiff_s2;
	logic [32:0] mdiff_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s2      <= item_s1.op;
		nan_s2     <= item_s1.nan;
		tindex_s2  <= item_s1.tindex;
		tcolor_s2  <= item_s1.tcolor;
		abs_smp_s2 <= abs_smp;
		fdiff_s2   <= fdiff;
		mdiff_s2   <= mdiff;
	end

	// stage 2 -> 3: missing test and scaling product
	logic [32:0] fabs;
	logic        missing;
	logic        pos;

	assign fabs    = fdiff_s2[32] ? (~fdiff_s2 + 33'd1) : fdiff_s2;
	assign missing = nan_s2
	              || (abs_smp_s2 > {1'b0, cfg.mag_limit})
	              || (fabs < {1'b0, cfg.fill_tol});
	assign pos     = !mdiff_s2[32] && (mdiff_s2 != 33'd0);

	logic        vld_s3;
	op_t         op_s3;
	logic [7:0]  tindex_s3;
	logic [23:0] tcolor_s3;
	logic        missing_s3;
	logic        pos_s3;
	logic [63:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s3      <= op_s2;
		tindex_s3  <= tindex_s2;
		tcolor_s3  <= tcolor_s2;
		missing_s3 <= missing;
		pos_s3     <= pos;
		prod_s3    <= 64'(mdiff_s2[31:0]) * 64'(cfg.recip);
	end

	// stage 3: clamp the index, table read or write
	logic [47:0]   idx_full;
	logic [AW-1:0] idx;
	logic          we;

	assign idx_full = prod_s3[63:16];

	always_comb begin
		if (!pos_s3) begin
			idx = '0;
		end else if (idx_full > TOP) begin
			idx = TOP[AW-1:0];
		end else begin
			idx = idx_full[AW-1:0];
		end
	end

	assign we = vld_s3 && (op_s3 == OP_TABLE) && ({1'b0, tindex_s3} < 9'(TABLE_ENTRIES));

	logic [RGB_W-1:0] rdata;

	pcm_ram #(
		.WIDTH(RGB_W),
		.DEPTH(TABLE_ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (we),
		.waddr (tindex_s3[AW-1:0]),
		.wdata (tcolor_s3),
		.raddr (idx),
		.rdata (rdata)
	);

	// stage 4: color ready, into the queue
	logic vld_s4;
	logic map_s4;
	logic missing_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		map_s4     <= (op_s3 == OP_MAP);
		missing_s4 <= missing_s3;
	end

	assign push              = vld_s4 && map_s4;
	assign push_item.missing = missing_s4;
	assign push_item.rgb     = missing_s4 ? {GRAY_LEVEL, GRAY_LEVEL, GRAY_LEVEL} : rdata;

endmodule

// File: hdl/pcm_queue.sv
// Small FIFO between the front end and the pixel replicator.
module pcm_queue import pcm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  q_item_t push_item,
	input  logic    pop,
	output logic    q_valid,
	output q_item_t q_item
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	q_item_t       ent_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign q_valid = (cnt_q != '0);
	assign q_item  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CW'(1);
				2'b01:   cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: hdl/pcm_back.sv
// Back end: replicates each sample into a scale x scale block and tracks display position.
module pcm_back import pcm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_valid,
	input  q_item_t q_item,
	output logic    pop,
	output logic    out_valid,
	input  logic    out_ready,
	output pixel_t  out_pix
);

	logic               ov_q;
	logic               last_q;
	logic               missing_q;
	logic [RGB_W-1:0]   rgb_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [COORD_W-1:0] base_x_q;
	logic [SUB_W-1:0]   sx_q;
	logic [SUB_W-1:0]   sy_q;
	logic [POS_W-1:0]   col_q;
	logic [POS_W-1:0]   row_q;

	logic [SUB_W-1:0]   scale_m1;
	logic               blk_done;
	logic               step;
	logic [SUB_W-1:0]   nsx;
	logic [SUB_W-1:0]   nsy;
	logic [15:0]        bx;
	logic [15:0]        by;
	logic [POS_W-1:0]   col_inc;
	logic [POS_W-1:0]   row_inc;
	logic               col_wrap;
	logic               row_wrap;

	assign scale_m1 = SUB_W'(cfg.scale - SCALE_W'(1));
	assign blk_done = ov_q && out_ready && last_q;
	assign pop      = q_valid && (!ov_q || blk_done);
	assign step     = ov_q && out_ready && !last_q;

	// next sub-pixel inside the block
	always_comb begin
		if (sx_q == scale_m1) begin
			nsx = '0;
			nsy = sy_q + SUB_W'(1);
		end else begin
			nsx = sx_q + SUB_W'(1);
			nsy = sy_q;
		end
	end

	assign bx = 16'(col_q) * 16'(cfg.scale);
	assign by = 16'(row_q) * 16'(cfg.scale);

	assign col_inc  = col_q + POS_W'(1);
	assign row_inc  = row_q + POS_W'(1);
	assign col_wrap = ({1'b0, col_inc} >= cfg.ncols) || (col_inc == '0);
	assign row_wrap = ({1'b0, row_inc} >= cfg.nrows) || (row_inc == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			col_q <= '0;
			row_q <= '0;
		end else begin
			if (pop) begin
				ov_q <= 1'b1;
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_inc;
				end else begin
					col_q <= col_inc;
				end
			end else if (blk_done) begin
				ov_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rgb_q     <= q_item.rgb;
			missing_q <= q_item.missing;
			sx_q      <= '0;
			sy_q      <= '0;
			last_q    <= (scale_m1 == '0);
			x_q       <= bx[COORD_W-1:0];
			base_x_q  <= bx[COORD_W-1:0];
			y_q       <= by[COORD_W-1:0];
		end else if (step) begin
			sx_q   <= nsx;
			sy_q   <= nsy;
			last_q <= (nsx == scale_m1) && (nsy == scale_m1);
			if (sx_q == scale_m1) begin
				x_q <= base_x_q;
				y_q <= y_q + COORD_W'(1);
			end else begin
				x_q <= x_q + COORD_W'(1);
			end
		end
	end

	assign out_valid       = ov_q;
	assign out_pix.red     = rgb_q[23:16];
	assign out_pix.green   = rgb_q[15:8];
	assign out_pix.blue    = rgb_q[7:0];
	assign out_pix.x       = x_q;
	assign out_pix.y       = y_q;
	assign out_pix.missing = missing_q;
	assign out_pix.last    = last_q;

endmodule

// File: hdl/pseudocolor_map_replicate.sv
// Top level of the pseudocolor mapper: config registers, front end, queue, pixel replicator.
//
//  channel | direction | handshake            | beat carries
//  --------+-----------+----------------------+---------------------------------------------
//  s_      | in        | s_tvalid / s_tready  | one sample to map or one color table write
//  m_      | out       | m_tvalid / m_tready  | one display pixel, tlast on the block's end
//  cfg_    | in        | cfg_valid/cfg_ready  | one register write (index, data)
//
//  A sample's beat passes the front pipe registers, the queue and the output register before
//  its first pixel leaves; the front pipe (subtract, 32x32 multiply, table RAM read) takes one
//  beat per cycle while s_tready is high. The output emits one pixel per cycle while m_tready
//  is high, so a sample holds it for scale^2 pixels; s_tready drops once 8 map beats
//  sit in the front pipe and queue. Table writes flow through the same pipe in order
//  and make no pixels. Reset clears control and positions only; the color table has no
//  clearing pass and is undefined until written. cfg_ready is always high.
module pseudocolor_map_replicate import pcm_pkg::*; #(
	parameter int TABLE_ENTRIES = PCM_TABLE_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // sample[31:0], table_index[39:32], table_color[63:40]
	input  logic [1:0]  s_tuser,   // op[0], sample_is_nan[1]
	// output stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // red[7:0], green[15:8], blue[23:16],
	                               // display_x[38:24], display_y[53:39], zero[55:54]
	output logic [0:0]  m_tuser,   // missing[0]
	output logic        m_tlast,
	// configuration writes
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	// raw configuration registers
	logic [31:0]        min_value_q;
	logic [31:0]        recip_q;
	logic [31:0]        fill_mark_q;
	logic [31:0]        fill_tol_q;
	logic [30:0]        mag_limit_q;
	logic [SCALE_W-1:0] scale_q;
	logic [SIZE_W-1:0]  columns_q;
	logic [SIZE_W-1:0]  rows_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_value_q  <= 32'd0;
			recip_q      <= 32'd255;
			fill_mark_q  <= 32'd0;
			fill_tol_q   <= 32'd0;
			mag_limit_q  <= 31'h7FFF_FFFF;
			scale_q      <= SCALE_W'(1);
			columns_q    <= SIZE_W'(4096);
			rows_q       <= SIZE_W'(4096);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_MIN_VALUE:  min_value_q  <= cfg_data;
				CFG_RECIP:      recip_q      <= cfg_data;
				CFG_FILL_MARK:  fill_mark_q  <= cfg_data;
				CFG_FILL_TOL:   fill_tol_q   <= cfg_data;
				CFG_MAG_LIMIT:  mag_limit_q  <= cfg_data[30:0];
				CFG_SCALE:      scale_q      <= cfg_data[SCALE_W-1:0];
				CFG_COLUMNS:    columns_q    <= cfg_data[SIZE_W-1:0];
				CFG_ROWS:       rows_q       <= cfg_data[SIZE_W-1:0];
				default:        ;  // unused index, write dropped
			endcase
		end
	end

	// effective settings: zero sizes act as one, large ones saturate
	cfg_t cfg;

	always_comb begin
		cfg.min_value  = min_value_q;
		cfg.recip      = recip_q;
		cfg.fill_mark  = fill_mark_q;
		cfg.fill_tol   = fill_tol_q;
		cfg.mag_limit  = mag_limit_q;
		if (scale_q == '0) begin
			cfg.scale = SCALE_W'(1);
		end else if (scale_q > SCALE_W'(MAX_SCALE)) begin
			cfg.scale = SCALE_W'(MAX_SCALE);
		end else begin
			cfg.scale = scale_q;
		end
		if (columns_q == '0) begin
			cfg.ncols = SIZE_W'(1);
		end else if (columns_q > SIZE_W'(MAX_COLUMNS)) begin
			cfg.ncols = SIZE_W'(MAX_COLUMNS);
		end else begin
			cfg.ncols = columns_q;
		end
		if (rows_q == '0) begin
			cfg.nrows = SIZE_W'(1);
		end else if (rows_q > SIZE_W'(MAX_ROWS)) begin
			cfg.nrows = SIZE_W'(MAX_ROWS);
		end else begin
			cfg.nrows = rows_q;
		end
	end

	// unpack the input beat
	in_item_t in_item;

	assign in_item.op     = op_t'(s_tuser[0]);
	assign in_item.nan    = s_tuser[1];
	assign in_item.sample = s_tdata[31:0];
	assign in_item.tindex = s_tdata[39:32];
	assign in_item.tcolor = s_tdata[63:40];

	logic    push;
	logic    pop;
	logic    q_valid;
	q_item_t push_item;
	q_item_t q_item;
	pixel_t  pix;

	pcm_front #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_item   (in_item),
		.pop       (pop),
		.push      (push),
		.push_item (push_item)
	);

	pcm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.q_valid   (q_valid),
		.q_item    (q_item)
	);

	pcm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_pix   (pix)
	);

	assign m_tdata    = {2'b00, pix.y, pix.x, pix.blue, pix.green, pix.red};
	assign m_tuser[0] = pix.missing;
	assign m_tlast    = pix.last;

endmodule

// File: hdl/pcm_checker.sv
// Port-level checker for the pseudocolor mapper, bound to the top level.
`include "pseudocolor_map_replicate_macros.svh"

module pcm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [0:0]  m_tuser,
	input logic        m_tlast
);

	`PCM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled output beat changed")

	`PCM_ASSERT_IMPLY(a_missing_gray, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[23:0] == 24'h1E1E1E, "missing pixel is not gray")

	`PCM_ASSERT_NEXT(a_block_cont, clk, arst_n, m_tvalid && m_tready && !m_tlast, m_tvalid && $stable(m_tuser) && $stable(m_tdata[23:0]), "block broke before its last pixel")

	// valid may still be unknown at the very first edge, before reset has acted
	`PCM_ASSERT_ALWAYS(a_reset_idle, clk, !arst_n, m_tvalid !== 1'b1, "output valid during reset")

endmodule

bind pseudocolor_map_replicate pcm_checker u_pcm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
